>>> design/oas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oas_pkg
// Shared types and constants of the obstacle avoidance sequencer.
// ----------------------------------------------------------------------------
package oas_pkg;

    localparam int YAW_W   = 32;
    localparam int RAW_W   = 16;
    localparam int DIST_W  = 16;
    localparam int GAIN_W  = 8;
    localparam int CNT_W   = 8;
    localparam int DEG_W   = 9;
    localparam int MODE_W  = 3;
    localparam int STEER_W = 8;
    localparam int OUTY_W  = 16;
    localparam int CFG_AW  = 3;
    localparam int CFG_DW  = 16;

    // request kinds
    localparam logic OP_GYRO = 1'b0;
    localparam logic OP_DIST = 1'b1;

    // register indexes
    localparam logic [CFG_AW-1:0] REG_DIST_THR   = 3'd0;
    localparam logic [CFG_AW-1:0] REG_TRIG_CNT   = 3'd1;
    localparam logic [CFG_AW-1:0] REG_YAW_LEFT   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_YAW_RSTART = 3'd3;
    localparam logic [CFG_AW-1:0] REG_YAW_REND   = 3'd4;
    localparam logic [CFG_AW-1:0] REG_GYRO_GAIN  = 3'd5;

    // external mode codes
    localparam logic [MODE_W-1:0] CODE_IDLE  = 3'd0;
    localparam logic [MODE_W-1:0] CODE_LEFT  = 3'd1;
    localparam logic [MODE_W-1:0] CODE_L2R   = 3'd2;
    localparam logic [MODE_W-1:0] CODE_RIGHT = 3'd3;
    localparam logic [MODE_W-1:0] CODE_DONE  = 3'd4;

    localparam logic signed [STEER_W-1:0] STEER_IDLE  = 8'sd0;
    localparam logic signed [STEER_W-1:0] STEER_LEFT  = 8'sd70;
    localparam logic signed [STEER_W-1:0] STEER_L2R   = -8'sd60;
    localparam logic signed [STEER_W-1:0] STEER_RIGHT = 8'sd50;
    localparam logic signed [STEER_W-1:0] STEER_DONE  = 8'sd0;

    localparam logic signed [DEG_W-1:0] DONE_EXIT_DEG = -9'sd5;

    // reset values of the registers
    localparam logic [DIST_W-1:0]       RST_DIST_THR   = 16'd300;
    localparam logic [CNT_W-1:0]        RST_TRIG_CNT   = 8'd5;
    localparam logic signed [DEG_W-1:0] RST_YAW_LEFT   = 9'sd40;
    localparam logic signed [DEG_W-1:0] RST_YAW_RSTART = -9'sd32;
    localparam logic signed [DEG_W-1:0] RST_YAW_REND   = -9'sd5;
    localparam logic [GAIN_W-1:0]       RST_GYRO_GAIN  = 8'd20;

    typedef enum logic [4:0] {
        M_IDLE  = 5'b00001,
        M_LEFT  = 5'b00010,
        M_L2R   = 5'b00100,
        M_RIGHT = 5'b01000,
        M_DONE  = 5'b10000
    } mode_t;

    function automatic logic [MODE_W-1:0] mode_code(input mode_t m);
        logic [MODE_W-1:0] c;
        case (m)
            M_LEFT:  c = CODE_LEFT;
            M_L2R:   c = CODE_L2R;
            M_RIGHT: c = CODE_RIGHT;
            M_DONE:  c = CODE_DONE;
            default: c = CODE_IDLE;
        endcase
        return c;
    endfunction

    function automatic logic signed [STEER_W-1:0] steer_for(input mode_t m);
        logic signed [STEER_W-1:0] s;
        case (m)
            M_LEFT:  s = STEER_LEFT;
            M_L2R:   s = STEER_L2R;
            M_RIGHT: s = STEER_RIGHT;
            M_DONE:  s = STEER_DONE;
            default: s = STEER_IDLE;
        endcase
        return s;
    endfunction

    // yaw strictly above / below deg * 65536
    function automatic logic yaw_gt(input logic signed [YAW_W-1:0] y,
                                    input logic signed [DEG_W-1:0] d);
        logic signed [YAW_W-1:0] lim;
        lim = {{(YAW_W-DEG_W-16){d[DEG_W-1]}}, d, 16'h0000};
        return y > lim;
    endfunction

    function automatic logic yaw_lt(input logic signed [YAW_W-1:0] y,
                                    input logic signed [DEG_W-1:0] d);
        logic signed [YAW_W-1:0] lim;
        lim = {{(YAW_W-DEG_W-16){d[DEG_W-1]}}, d, 16'h0000};
        return y < lim;
    endfunction

endpackage
`default_nettype wire

>>> design/oas_yaw_integ.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oas_yaw_integ
// Gyro rate decode, gain multiply and saturating add into the Q16 yaw.
// ----------------------------------------------------------------------------
module oas_yaw_integ (
    input  wire logic signed [oas_pkg::YAW_W-1:0]  yaw_in,
    input  wire logic        [oas_pkg::RAW_W-1:0]  gyro_raw,
    input  wire logic        [oas_pkg::GAIN_W-1:0] gain,
    output logic signed      [oas_pkg::YAW_W-1:0]  yaw_out
);
    import oas_pkg::*;

    localparam int RATE_W = RAW_W + 1;
    localparam int PROD_W = RATE_W + GAIN_W + 1;
    localparam int SUM_W  = YAW_W + 2;

    logic signed [RATE_W-1:0] rate;
    logic signed [GAIN_W:0]   gain_s;
    logic signed [PROD_W-1:0] prod;
    logic signed [SUM_W-1:0]  sum;

    // below mid-scale the rate is the negated raw word, else 65535 - raw
    assign rate   = gyro_raw[RAW_W-1] ? $signed({1'b0, ~gyro_raw})
                                      : -$signed({1'b0, gyro_raw});
    assign gain_s = $signed({1'b0, gain});
    assign prod   = rate * gain_s;
    assign sum    = $signed({{(SUM_W-YAW_W){yaw_in[YAW_W-1]}}, yaw_in})
                  + $signed({{(SUM_W-PROD_W){prod[PROD_W-1]}}, prod});

    always_comb begin
        if (sum[SUM_W-1:YAW_W-1] == '0 || sum[SUM_W-1:YAW_W-1] == '1) begin
            yaw_out = sum[YAW_W-1:0];
        end else if (sum[SUM_W-1]) begin
            yaw_out = {1'b1, {(YAW_W-1){1'b0}}};
        end else begin
            yaw_out = {1'b0, {(YAW_W-1){1'b1}}};
        end
    end

endmodule
`default_nettype wire

>>> design/obstacle_avoid_sequencer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// obstacle_avoid_sequencer
// Yaw integrator and five-mode obstacle avoidance sequencer.
// ----------------------------------------------------------------------------
// Requests come in on the s_ channel: s_opcode 0 is a gyro sample that adds
// gain * rate to the Q16 yaw, 1 is a distance tick that steps the close
// counter and the mode sequence. Every request gives one result on the m_
// channel: the mode after it, its steering value and the yaw in whole degrees.
// A request is held in the input register, where the yaw multiply-add
// and the mode step are done, and its result is written to the output
// register when the request advances. One request is taken every cycle
// while the output does not stall; the state is updated as each request
// leaves the input register, so back-to-back requests see each other's state.
// When the receiver stalls the result register holds, one more request can
// wait in the input register, then s_ready drops until m_ready returns.
// Synchronous reset clears the pipeline, yaw, counter and mode (idle) and
// loads the register defaults. The user writes registers via cfg_wr_en /
// cfg_addr / cfg_wdata while no request is in flight; the block does not check.
// ----------------------------------------------------------------------------
module obstacle_avoid_sequencer (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               cfg_wr_en,
    input  wire logic        [oas_pkg::CFG_AW-1:0]  cfg_addr,
    input  wire logic        [oas_pkg::CFG_DW-1:0]  cfg_wdata,
    input  wire logic                               s_valid,
    output logic                                    s_ready,
    input  wire logic                               s_opcode,
    input  wire logic        [oas_pkg::RAW_W-1:0]   s_gyro_raw,
    input  wire logic        [oas_pkg::DIST_W-1:0]  s_distance_mm,
    output logic                                    m_valid,
    input  wire logic                               m_ready,
    output logic             [oas_pkg::MODE_W-1:0]  m_mode,
    output logic signed      [oas_pkg::STEER_W-1:0] m_steer,
    output logic signed      [oas_pkg::OUTY_W-1:0]  m_yaw_deg
);
    import oas_pkg::*;

    // configuration
    logic        [DIST_W-1:0] dist_thr_reg;
    logic        [CNT_W-1:0]  trig_cnt_reg;
    logic signed [DEG_W-1:0]  yaw_left_reg;
    logic signed [DEG_W-1:0]  yaw_rstart_reg;
    logic signed [DEG_W-1:0]  yaw_rend_reg;
    logic        [GAIN_W-1:0] gain_reg;

    // input register
    logic              in_vld_reg;
    logic              op_reg;
    logic [RAW_W-1:0]  raw_reg;
    logic [DIST_W-1:0] dist_reg;

    // block state
    mode_t                    mode_reg, mode_next;
    logic        [CNT_W-1:0]  cnt_reg, cnt_next, cnt_inc;
    logic signed [YAW_W-1:0]  yaw_reg, yaw_next, yaw_sum;

    // result register
    logic                      out_vld_reg;
    logic [MODE_W-1:0]         mode_out_reg;
    logic signed [STEER_W-1:0] steer_out_reg;
    logic signed [OUTY_W-1:0]  yaw_out_reg;

    logic adv;

    assign adv     = in_vld_reg && (!out_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_thr_reg   <= RST_DIST_THR;
            trig_cnt_reg   <= RST_TRIG_CNT;
            yaw_left_reg   <= RST_YAW_LEFT;
            yaw_rstart_reg <= RST_YAW_RSTART;
            yaw_rend_reg   <= RST_YAW_REND;
            gain_reg       <= RST_GYRO_GAIN;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_DIST_THR:   dist_thr_reg   <= cfg_wdata[DIST_W-1:0];
                REG_TRIG_CNT:   trig_cnt_reg   <= cfg_wdata[CNT_W-1:0];
                REG_YAW_LEFT:   yaw_left_reg   <= $signed(cfg_wdata[DEG_W-1:0]);
                REG_YAW_RSTART: yaw_rstart_reg <= $signed(cfg_wdata[DEG_W-1:0]);
                REG_YAW_REND:   yaw_rend_reg   <= $signed(cfg_wdata[DEG_W-1:0]);
                REG_GYRO_GAIN:  gain_reg       <= cfg_wdata[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            op_reg   <= s_opcode;
            raw_reg  <= s_gyro_raw;
            dist_reg <= s_distance_mm;
        end
    end

    oas_yaw_integ u_yaw (
        .yaw_in   (yaw_reg),
        .gyro_raw (raw_reg),
        .gain     (gain_reg),
        .yaw_out  (yaw_sum)
    );

    // counter is only incremented while below trig_cnt_reg, so the increment cannot wrap
    assign cnt_inc = cnt_reg + CNT_W'(1);

    always_comb begin
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        yaw_next  = yaw_reg;
        if (op_reg == OP_GYRO) begin
            yaw_next = yaw_sum;
        end else begin
            if (dist_reg < dist_thr_reg) begin
                if (cnt_reg < trig_cnt_reg) begin
                    cnt_next = cnt_inc;
                end
            end else begin
                cnt_next = '0;
            end
            case (mode_reg)
                M_IDLE: begin
                    if (cnt_next >= trig_cnt_reg) begin
                        yaw_next  = '0;
                        mode_next = M_LEFT;
                        cnt_next  = '0;
                    end
                end
                M_LEFT: begin
                    if (yaw_gt(yaw_reg, yaw_left_reg)) mode_next = M_L2R;
                end
                M_L2R: begin
                    if (yaw_lt(yaw_reg, yaw_rstart_reg)) mode_next = M_RIGHT;
                end
                M_RIGHT: begin
                    if (yaw_gt(yaw_reg, yaw_rend_reg)) mode_next = M_DONE;
                end
                M_DONE: begin
                    if (yaw_gt(yaw_reg, DONE_EXIT_DEG)) mode_next = M_IDLE;
                end
                default: begin
                    mode_next = M_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg    <= M_IDLE;
            cnt_reg     <= '0;
            yaw_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else begin
            if (adv) begin
                mode_reg <= mode_next;
                cnt_reg  <= cnt_next;
                yaw_reg  <= yaw_next;
            end
            if (adv) begin
                out_vld_reg <= 1'b1;
            end else if (m_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
        if (adv) begin
            mode_out_reg  <= mode_code(mode_next);
            steer_out_reg <= steer_for(mode_next);
            // floor of the Q16 value is its upper half
            yaw_out_reg   <= yaw_next[YAW_W-1:YAW_W-OUTY_W];
        end
    end

    assign m_valid   = out_vld_reg;
    assign m_mode    = mode_out_reg;
    assign m_steer   = steer_out_reg;
    assign m_yaw_deg = yaw_out_reg;

endmodule
`default_nettype wire
